>>> design/vp8ks_pkg.sv
// Shared types and constants for the VP8 key-frame header scanner.
// No dependencies; every design file refers to it by scoped names.
`default_nettype none

package vp8ks_pkg;

    localparam int STATUS_BITS = 3;
    localparam int DISCARD_BITS = 24;
    localparam int PROFILE_BITS = 4;
    localparam int DIM_BITS = 14;
    localparam int ALIGN_BITS = 15;
    localparam int PSIZE_BITS = 19;
    localparam int RESULT_BITS = STATUS_BITS + DISCARD_BITS + PROFILE_BITS
                                 + 2 * DIM_BITS + 2 * ALIGN_BITS + PSIZE_BITS;
    localparam int M_DATA_BITS = ((RESULT_BITS + 7) / 8) * 8;

    localparam logic [STATUS_BITS-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_NO_CODE    = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_MORE       = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_INTER      = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_INCOMPLETE = 3'd4;

    localparam logic [7:0] CODE_BYTE0 = 8'h9d;
    localparam logic [7:0] CODE_BYTE1 = 8'h01;
    localparam logic [7:0] CODE_BYTE2 = 8'h2a;

    localparam logic [2:0] SIZE_BYTES = 3'd4;
    localparam int HIST_DEPTH = 5;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } beat_t;

    // last field in the lowest bits
    typedef struct packed {
        logic [PSIZE_BITS-1:0]   partition_size;
        logic [ALIGN_BITS-1:0]   aligned_height;
        logic [ALIGN_BITS-1:0]   aligned_width;
        logic [DIM_BITS-1:0]     crop_height;
        logic [DIM_BITS-1:0]     crop_width;
        logic [PROFILE_BITS-1:0] profile;
        logic [DISCARD_BITS-1:0] discard_count;
        logic [STATUS_BITS-1:0]  status;
    } result_t;

endpackage

`default_nettype wire

>>> design/vp8ks_in_reg.sv
// Input register stage of the VP8 key-frame header scanner.
// Holds one accepted beat until the scan stage takes it; uses vp8ks_pkg.
`default_nettype none

module vp8ks_in_reg (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_tvalid,
    output logic               s_tready,
    input  vp8ks_pkg::beat_t   s_beat,
    input  wire                take,
    output logic               beat_valid,
    output vp8ks_pkg::beat_t   beat
);

    logic             valid_reg;
    logic             valid_next;
    vp8ks_pkg::beat_t beat_reg;

    assign s_tready   = !valid_reg || take;
    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            beat_reg <= s_beat;
        end
    end

    a_take_needs_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        take |-> valid_reg)
        else $error("scan stage took a beat from an empty input register");

    a_hold_until_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !take |=> valid_reg && $stable(beat_reg))
        else $error("input register lost a beat that was not taken");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg |-> s_tready)
        else $error("empty input register refused a beat");

endmodule

`default_nettype wire

>>> design/vp8ks_scan.sv
// Scan state and result logic of the VP8 key-frame header scanner.
// Tracks the start code, frame tag and size bytes; uses vp8ks_pkg.
`default_nettype none

module vp8ks_scan #(
    parameter int COUNT_BITS = 24
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 fire,
    input  vp8ks_pkg::beat_t    beat,
    output vp8ks_pkg::result_t  result
);

    localparam logic [COUNT_BITS-1:0] CNT_FIVE = COUNT_BITS'(5);
    localparam logic [COUNT_BITS-1:0] CNT_SIX  = COUNT_BITS'(6);
    localparam int HIST_IDX = vp8ks_pkg::HIST_DEPTH - 1;

    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic                  found_reg, found_next;
    logic [2:0]            seen_reg, seen_next;
    logic [COUNT_BITS-1:0] tag_off_reg, tag_off_next;
    logic [23:0]           tag_reg, tag_next;
    logic [31:0]           size_reg, size_next;
    logic [7:0]            hist_reg [HIST_IDX:0];
    logic [7:0]            hist_next [HIST_IDX:0];

    logic [COUNT_BITS-1:0] len;
    logic                  match;
    logic [31:0]           len_wide;
    logic [31:0]           off_wide;
    logic [33:0]           part_end;
    logic [vp8ks_pkg::DIM_BITS-1:0]   w;
    logic [vp8ks_pkg::DIM_BITS-1:0]   h;
    logic [vp8ks_pkg::ALIGN_BITS-1:0] w_up;
    logic [vp8ks_pkg::ALIGN_BITS-1:0] h_up;
    logic [vp8ks_pkg::PSIZE_BITS-1:0] psize;

    always_comb begin
        len = (&cnt_reg) ? cnt_reg : cnt_reg + 1'b1;

        for (int k = 0; k < HIST_IDX; k++) begin
            hist_next[k] = hist_reg[k+1];
        end
        hist_next[HIST_IDX] = beat.data;

        found_next   = found_reg;
        seen_next    = seen_reg;
        tag_off_next = tag_off_reg;
        tag_next     = tag_reg;
        size_next    = size_reg;

        if (found_reg && seen_reg < vp8ks_pkg::SIZE_BYTES) begin
            case (seen_reg[1:0])
                2'd0: size_next[7:0]   = beat.data;
                2'd1: size_next[15:8]  = beat.data;
                2'd2: size_next[23:16] = beat.data;
                2'd3: size_next[31:24] = beat.data;
                default: size_next = size_reg;
            endcase
            seen_next = seen_reg + 3'd1;
        end

        match = !found_reg && (cnt_reg >= CNT_FIVE) &&
                (hist_reg[3] == vp8ks_pkg::CODE_BYTE0) &&
                (hist_reg[4] == vp8ks_pkg::CODE_BYTE1) &&
                (beat.data == vp8ks_pkg::CODE_BYTE2);
        if (match) begin
            found_next   = 1'b1;
            tag_off_next = cnt_reg - CNT_FIVE;
            tag_next     = {hist_reg[2], hist_reg[1], hist_reg[0]};
            size_next    = '0;
            seen_next    = '0;
        end

        len_wide = 32'(len);
        off_wide = 32'(tag_off_next);
        psize    = tag_next[23:5];
        part_end = 34'(off_wide) + 34'(psize);
        w        = size_next[13:0];
        h        = size_next[29:16];
        w_up     = ({1'b0, w} + 15'd15) & ~15'h000f;
        h_up     = ({1'b0, h} + 15'd15) & ~15'h000f;

        result = '0;
        if (!found_next) begin
            if (len < CNT_SIX) begin
                result.status = vp8ks_pkg::ST_MORE;
            end else begin
                result.status        = vp8ks_pkg::ST_NO_CODE;
                result.discard_count = 24'(len_wide - 32'd6);
            end
        end else if (tag_next[0]) begin
            result.status  = vp8ks_pkg::ST_INTER;
            result.profile = {1'b0, tag_next[3:1]} + 4'd1;
        end else if (part_end > 34'(len_wide) || seen_next < vp8ks_pkg::SIZE_BYTES) begin
            result.status = vp8ks_pkg::ST_INCOMPLETE;
        end else begin
            result.status         = vp8ks_pkg::ST_OK;
            result.discard_count  = off_wide[23:0];
            result.profile        = {1'b0, tag_next[3:1]} + 4'd1;
            result.crop_width     = w;
            result.crop_height    = h;
            result.aligned_width  = w_up;
            result.aligned_height = h_up;
            result.partition_size = psize;
        end

        cnt_next = len;
        if (beat.last) begin
            cnt_next   = '0;
            found_next = 1'b0;
            seen_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            found_reg <= 1'b0;
            seen_reg  <= '0;
        end else if (fire) begin
            cnt_reg   <= cnt_next;
            found_reg <= found_next;
            seen_reg  <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            tag_off_reg <= tag_off_next;
            tag_reg     <= tag_next;
            size_reg    <= size_next;
            for (int k = 0; k <= HIST_IDX; k++) begin
                hist_reg[k] <= hist_next[k];
            end
        end
    end

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && beat.last |=> cnt_reg == '0 && !found_reg && seen_reg == '0)
        else $error("scan state not cleared after the last beat of a buffer");

    a_seen_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg <= vp8ks_pkg::SIZE_BYTES)
        else $error("size byte count ran past four");

    a_match_latches: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && match && !beat.last |=> found_reg && seen_reg == '0)
        else $error("start code match not latched");

endmodule

`default_nettype wire

>>> design/vp8_keyframe_header_scanner_top.sv
// Top level of the VP8 key-frame header scanner: input register, scan logic
// and result register. Depends on vp8ks_pkg, vp8ks_in_reg and vp8ks_scan.
//
//  channel | dir | beat fields (tdata low bit up)                  | per
//  s_      | in  | data_byte; tlast = last_byte                    | bitstream byte
//  m_      | out | status, discard_count, profile, crop_width,     | buffer (one on
//          |     | crop_height, aligned_width, aligned_height,     | its last byte)
//          |     | partition_size, 4 zero pad bits                 |
//
// One input beat per clock cycle, but for the stall below; scan state is registered.
// m_ presents a result from its register once a buffer's last beat is scanned.
// Reset clears the scan state at once; no clearing pass.
// A waiting result stalls the input only when the next beat to process is a last beat.
`default_nettype none

module vp8_keyframe_header_scanner_top #(
    parameter int COUNT_BITS = 24
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    input  wire  [7:0]                           s_tdata,  // data_byte[7:0]
    input  wire                                  s_tlast,
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    // status[2:0], discard_count[26:3], profile[30:27], crop_width[44:31],
    // crop_height[58:45], aligned_width[73:59], aligned_height[88:74],
    // partition_size[107:89], zero[111:108]
    output logic [vp8ks_pkg::M_DATA_BITS-1:0]    m_tdata
);

    vp8ks_pkg::beat_t   s_beat;
    vp8ks_pkg::beat_t   beat;
    vp8ks_pkg::result_t result;
    vp8ks_pkg::result_t res_reg;
    logic               beat_valid;
    logic               advance;
    logic               m_valid_reg, m_valid_next;

    assign s_beat.data = s_tdata;
    assign s_beat.last = s_tlast;

    assign advance = beat_valid && (!beat.last || !m_valid_reg || m_tready);

    vp8ks_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_beat     (s_beat),
        .take       (advance),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    vp8ks_scan #(
        .COUNT_BITS (COUNT_BITS)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .beat    (beat),
        .result  (result)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance && beat.last) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && beat.last) begin
            res_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(vp8ks_pkg::M_DATA_BITS - vp8ks_pkg::RESULT_BITS){1'b0}}, res_reg};

    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && beat.last |=> m_tvalid)
        else $error("last beat processed without a result");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_tready |-> !(advance && beat.last))
        else $error("result register overwritten while waiting");

    a_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res_reg.status != vp8ks_pkg::ST_OK |->
            res_reg.partition_size == '0 && res_reg.crop_width == '0)
        else $error("size fields set on a non-ok result");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> res_reg.status <= vp8ks_pkg::ST_INCOMPLETE)
        else $error("result status out of range");

endmodule

`default_nettype wire
